@@ rtl/srbs_pkg.sv @@
package srbs_pkg;

  // Table geometry.
  localparam int TEXT_DEPTH = 65536;
  localparam int SYMBOLS    = 256;
  localparam int BYTES      = 256;

  localparam int PHI_AW  = $clog2(TEXT_DEPTH);
  localparam int SYM_AW  = $clog2(SYMBOLS + 1);
  localparam int BYTE_AW = $clog2(BYTES);

  // Field widths.
  localparam int PHI_W  = 16;
  localparam int VAL_W  = 17;
  localparam int ROW_W  = 17;
  localparam int IDX_W  = 18;
  localparam int CODE_W = 8;
  localparam int MAP_W  = CODE_W + 1;
  localparam int TIDX_W = 16;

  // Configuration port.
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 9;
  localparam int ALPHA_W = 9;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(256);

  typedef enum logic [CFG_IW-1:0] {
    CFG_ALPHABET_SIZE  = 1'b0,
    CFG_LAST_TEXT_BYTE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_WR_PHI   = 2'd0,
    ACT_WR_START = 2'd1,
    ACT_WR_CODE  = 2'd2,
    ACT_PATTERN  = 2'd3
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [TIDX_W-1:0]   table_index;
    logic [VAL_W-1:0]    table_value;
    logic                code_present;
    logic [CODE_W-1:0]   pattern_byte;
    logic                pattern_begin;
    logic                pattern_end;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] range_left;
    logic [ROW_W-1:0] range_right;
    logic [ROW_W-1:0] match_count;
    logic             found;
  } out_word_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MAP_B,
    OP_START0,
    OP_START1,
    OP_START2,
    OP_PHI_LO,
    OP_PHI_HI,
    OP_SRCH1,
    OP_TAIL1,
    OP_SRCH2,
    OP_TAIL2,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic go;
    logic more;
    logic pattern_end;
  } dp_status_t;

endpackage

@@ rtl/srbs_ctrl.sv @@
module srbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_is_pattern_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output srbs_pkg::dp_cmd_t    cmd_o,
  input  srbs_pkg::dp_status_t status_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_B,
    ST_START0,
    ST_START1,
    ST_START2,
    ST_PHI_LO,
    ST_PHI_HI,
    ST_SRCH1,
    ST_TAIL1,
    ST_SRCH2,
    ST_TAIL2,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = srbs_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = srbs_pkg::OP_ACCEPT;
          if (in_is_pattern_i) begin
            state_d = ST_MAP_B;
          end
        end
      end
      ST_MAP_B: begin
        cmd_o.op = srbs_pkg::OP_MAP_B;
        state_d  = status_i.go ? ST_START0 : ST_FINISH;
      end
      ST_START0: begin
        cmd_o.op = srbs_pkg::OP_START0;
        state_d  = ST_START1;
      end
      ST_START1: begin
        cmd_o.op = srbs_pkg::OP_START1;
        state_d  = ST_START2;
      end
      ST_START2: begin
        cmd_o.op = srbs_pkg::OP_START2;
        state_d  = status_i.go ? ST_PHI_LO : ST_FINISH;
      end
      ST_PHI_LO: begin
        cmd_o.op = srbs_pkg::OP_PHI_LO;
        state_d  = status_i.go ? ST_PHI_HI : ST_FINISH;
      end
      ST_PHI_HI: begin
        cmd_o.op = srbs_pkg::OP_PHI_HI;
        if (!status_i.go) begin
          state_d = ST_FINISH;
        end else if (status_i.more) begin
          state_d = ST_SRCH1;
        end else begin
          state_d = ST_TAIL1;
        end
      end
      ST_SRCH1: begin
        cmd_o.op = srbs_pkg::OP_SRCH1;
        state_d  = status_i.more ? ST_SRCH1 : ST_TAIL1;
      end
      ST_TAIL1: begin
        cmd_o.op = srbs_pkg::OP_TAIL1;
        state_d  = status_i.more ? ST_SRCH2 : ST_TAIL2;
      end
      ST_SRCH2: begin
        cmd_o.op = srbs_pkg::OP_SRCH2;
        state_d  = status_i.more ? ST_SRCH2 : ST_TAIL2;
      end
      ST_TAIL2: begin
        cmd_o.op = srbs_pkg::OP_TAIL2;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        // A result waits here until the output register is free.
        if (!status_i.pattern_end) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          cmd_o.op = srbs_pkg::OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == srbs_pkg::OP_FINISH) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/srbs_dp.sv @@
module srbs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srbs_pkg::in_word_t            in_word_i,
  input  logic                          cfg_we_i,
  input  logic [srbs_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [srbs_pkg::CFG_DW-1:0]   cfg_data_i,
  input  srbs_pkg::dp_cmd_t             cmd_i,
  output srbs_pkg::dp_status_t          status_o,
  output srbs_pkg::out_word_t           out_word_o
);

  localparam int IDX_W = srbs_pkg::IDX_W;
  localparam int ROW_W = srbs_pkg::ROW_W;

  // Tables.
  logic [srbs_pkg::PHI_W-1:0] phi_mem   [srbs_pkg::TEXT_DEPTH];
  logic [srbs_pkg::VAL_W-1:0] start_mem [srbs_pkg::SYMBOLS+1];
  logic [srbs_pkg::MAP_W-1:0] map_mem   [srbs_pkg::BYTES];

  logic [srbs_pkg::PHI_W-1:0]  phi_rd_q;
  logic                        phi_oob_q;
  logic [srbs_pkg::VAL_W-1:0]  start_rd_q;
  logic [srbs_pkg::MAP_W-1:0]  map_rd_q;

  // Configuration and search state.
  logic [srbs_pkg::ALPHA_W-1:0] alpha_q;
  logic [srbs_pkg::CODE_W-1:0]  last_byte_q;
  logic                         dead_q;
  logic [ROW_W-1:0]             cur_left_q, cur_right_q;

  logic                         begin_q, end_q;
  logic [srbs_pkg::CODE_W-1:0]  code_q;
  logic                         le_hit_q;
  logic [IDX_W-1:0]             lo_q, hi_q, ml_q, mr_q, mid_q, tl_q;
  srbs_pkg::out_word_t          out_q;

  // Addresses.
  logic [IDX_W-1:0]                  phi_addr;
  logic [srbs_pkg::SYM_AW-1:0]       start_addr;
  logic [srbs_pkg::BYTE_AW-1:0]      map_addr;

  logic [srbs_pkg::PHI_W-1:0] phi_val;
  logic [ROW_W-1:0]           phi_ext;
  logic                       lt_left, gt_right, in_rng;
  logic                       map_known, cur_empty, bkt_empty;
  logic [IDX_W-1:0]           hi_new, tr_new;
  logic [IDX_W-1:0]           step_ml, step_mr, step_mid, span;
  logic                       more;
  logic                       acc_write;

  assign acc_write = (cmd_i.op == srbs_pkg::OP_ACCEPT);

  // An index past the end of the phi table reads as zero.
  assign phi_val  = phi_oob_q ? '0 : phi_rd_q;
  assign phi_ext  = ROW_W'(phi_val);
  assign lt_left  = phi_ext < cur_left_q;
  assign gt_right = phi_ext > cur_right_q;
  assign in_rng   = !lt_left && !gt_right;

  assign map_known = map_rd_q[srbs_pkg::CODE_W] &&
                     (srbs_pkg::ALPHA_W'(map_rd_q[srbs_pkg::CODE_W-1:0]) < alpha_q);
  assign cur_empty = cur_left_q > cur_right_q;
  assign bkt_empty = lo_q >= IDX_W'(start_rd_q);
  assign hi_new    = IDX_W'(start_rd_q) - IDX_W'(1);
  assign tr_new    = in_rng ? mr_q : ml_q;

  // One bisection step per cycle; the next read address follows from it.
  always_comb begin
    step_ml = ml_q;
    step_mr = mr_q;
    case (cmd_i.op)
      srbs_pkg::OP_PHI_HI, srbs_pkg::OP_TAIL1: begin
        step_ml = lo_q;
        step_mr = hi_q;
      end
      srbs_pkg::OP_SRCH1: begin
        if (lt_left) begin
          step_ml = mid_q;
        end else begin
          step_mr = mid_q;
        end
      end
      srbs_pkg::OP_SRCH2: begin
        if (gt_right) begin
          step_mr = mid_q;
        end else begin
          step_ml = mid_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign span     = step_mr - step_ml;
  assign more     = span > IDX_W'(1);
  assign step_mid = IDX_W'(((IDX_W+1)'(step_ml) + (IDX_W+1)'(step_mr)) >> 1);

  always_comb begin
    phi_addr = '0;
    case (cmd_i.op)
      srbs_pkg::OP_START2:                      phi_addr = lo_q;
      srbs_pkg::OP_PHI_LO:                      phi_addr = hi_q;
      srbs_pkg::OP_PHI_HI, srbs_pkg::OP_SRCH1:  phi_addr = more ? step_mid : step_ml;
      srbs_pkg::OP_TAIL1, srbs_pkg::OP_SRCH2:   phi_addr = more ? step_mid : step_mr;
      default:                                  phi_addr = '0;
    endcase
  end

  always_comb begin
    start_addr = srbs_pkg::SYM_AW'(code_q);
    if (cmd_i.op == srbs_pkg::OP_START1) begin
      start_addr = srbs_pkg::SYM_AW'(code_q) + srbs_pkg::SYM_AW'(1);
    end
  end

  assign map_addr = (cmd_i.op == srbs_pkg::OP_ACCEPT) ? in_word_i.pattern_byte : last_byte_q;

  always_comb begin
    status_o.go          = 1'b0;
    status_o.more        = more;
    status_o.pattern_end = end_q;
    case (cmd_i.op)
      srbs_pkg::OP_MAP_B:  status_o.go = begin_q ? map_known
                                                 : (!dead_q && !cur_empty && map_known);
      srbs_pkg::OP_START2: status_o.go = !begin_q && !bkt_empty;
      srbs_pkg::OP_PHI_LO: status_o.go = !gt_right;
      srbs_pkg::OP_PHI_HI: status_o.go = !lt_left;
      default:             status_o.go = 1'b0;
    endcase
  end

  // Table ports: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (acc_write && in_word_i.action == srbs_pkg::ACT_WR_PHI &&
        32'(in_word_i.table_index) < srbs_pkg::TEXT_DEPTH) begin
      phi_mem[in_word_i.table_index[srbs_pkg::PHI_AW-1:0]] <=
        in_word_i.table_value[srbs_pkg::PHI_W-1:0];
    end
    phi_rd_q  <= phi_mem[phi_addr[srbs_pkg::PHI_AW-1:0]];
    phi_oob_q <= 32'(phi_addr) >= srbs_pkg::TEXT_DEPTH;
  end

  always_ff @(posedge clk_i) begin
    if (acc_write && in_word_i.action == srbs_pkg::ACT_WR_START &&
        32'(in_word_i.table_index) <= srbs_pkg::SYMBOLS) begin
      start_mem[in_word_i.table_index[srbs_pkg::SYM_AW-1:0]] <= in_word_i.table_value;
    end
    start_rd_q <= start_mem[start_addr];
  end

  always_ff @(posedge clk_i) begin
    if (acc_write && in_word_i.action == srbs_pkg::ACT_WR_CODE &&
        32'(in_word_i.table_index) < srbs_pkg::BYTES) begin
      map_mem[in_word_i.table_index[srbs_pkg::BYTE_AW-1:0]] <=
        {in_word_i.code_present, in_word_i.table_value[srbs_pkg::CODE_W-1:0]};
    end
    map_rd_q <= map_mem[map_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= srbs_pkg::ALPHA_RESET;
      last_byte_q <= '0;
      dead_q      <= 1'b0;
      cur_left_q  <= ROW_W'(1);
      cur_right_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srbs_pkg::CFG_ALPHABET_SIZE:  alpha_q     <= cfg_data_i[srbs_pkg::ALPHA_W-1:0];
          srbs_pkg::CFG_LAST_TEXT_BYTE: last_byte_q <= cfg_data_i[srbs_pkg::CODE_W-1:0];
          default: begin
          end
        endcase
      end
      case (cmd_i.op)
        srbs_pkg::OP_MAP_B: begin
          if (begin_q) begin
            dead_q <= !map_known;
          end else if (!dead_q && (cur_empty || !map_known)) begin
            dead_q <= 1'b1;
          end
        end
        srbs_pkg::OP_START2: begin
          if (bkt_empty) begin
            dead_q <= 1'b1;
          end else if (begin_q) begin
            cur_left_q  <= lo_q[ROW_W-1:0];
            cur_right_q <= hi_new[ROW_W-1:0];
          end
        end
        srbs_pkg::OP_PHI_LO: begin
          if (gt_right) begin
            dead_q <= 1'b1;
          end
        end
        srbs_pkg::OP_PHI_HI: begin
          if (lt_left) begin
            dead_q <= 1'b1;
          end
        end
        srbs_pkg::OP_TAIL2: begin
          if (tl_q > tr_new) begin
            dead_q <= 1'b1;
          end else begin
            cur_left_q  <= tl_q[ROW_W-1:0];
            cur_right_q <= tr_new[ROW_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      srbs_pkg::OP_ACCEPT: begin
        begin_q <= in_word_i.pattern_begin;
        end_q   <= in_word_i.pattern_end;
      end
      srbs_pkg::OP_MAP_B: begin
        code_q <= map_rd_q[srbs_pkg::CODE_W-1:0];
      end
      srbs_pkg::OP_START0: begin
        // The bucket of the text's final symbol starts one row later.
        le_hit_q <= map_rd_q[srbs_pkg::CODE_W] &&
                    (map_rd_q[srbs_pkg::CODE_W-1:0] == code_q) && !begin_q;
      end
      srbs_pkg::OP_START1: begin
        lo_q <= IDX_W'(start_rd_q) + IDX_W'(le_hit_q);
      end
      srbs_pkg::OP_START2: begin
        hi_q <= hi_new;
      end
      srbs_pkg::OP_PHI_HI, srbs_pkg::OP_SRCH1, srbs_pkg::OP_SRCH2: begin
        ml_q  <= step_ml;
        mr_q  <= step_mr;
        mid_q <= step_mid;
      end
      srbs_pkg::OP_TAIL1: begin
        tl_q  <= in_rng ? ml_q : mr_q;
        ml_q  <= step_ml;
        mr_q  <= step_mr;
        mid_q <= step_mid;
      end
      srbs_pkg::OP_FINISH: begin
        if (dead_q || cur_empty) begin
          out_q.range_left  <= ROW_W'(1);
          out_q.range_right <= '0;
          out_q.match_count <= '0;
          out_q.found       <= 1'b0;
        end else begin
          out_q.range_left  <= cur_left_q;
          out_q.range_right <= cur_right_q;
          out_q.match_count <= cur_right_q - cur_left_q + ROW_W'(1);
          out_q.found       <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_word_o = out_q;

endmodule

@@ rtl/suffix_range_backward_search_core.sv @@
// Table writes may follow back to back.
// A first pattern byte maps its code and reads its bucket bounds; a later byte also bisects
// the bucket for each end of the range, and ends early if the range dies.
// Only a byte that ends a pattern gives a result word, which is registered; a stalled result
// holds the next one. The input stalls while a pattern byte is in work.
// Asynchronous active-low reset clears the control state and the range and restores the
// configuration defaults; the tables are not cleared.
module suffix_range_backward_search_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  srbs_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output srbs_pkg::out_word_t           out_word_o,
  input  logic                          cfg_we_i,
  input  logic [srbs_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [srbs_pkg::CFG_DW-1:0]   cfg_data_i
);

  srbs_pkg::dp_cmd_t    cmd;
  srbs_pkg::dp_status_t status;
  logic                 in_is_pattern;

  assign in_is_pattern = (in_word_i.action == srbs_pkg::ACT_PATTERN);

  srbs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_is_pattern_i (in_is_pattern),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cmd_o           (cmd),
    .status_i        (status)
  );

  srbs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

@@ rtl/srbs_checker.sv @@
module srbs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_i,
  input srbs_pkg::in_word_t  in_word_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input srbs_pkg::out_word_t out_word_i
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_i;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i))
    else $error("result word changed while stalled");

  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.found |->
      out_word_i.range_left <= out_word_i.range_right &&
      out_word_i.match_count ==
        srbs_pkg::ROW_W'(out_word_i.range_right - out_word_i.range_left + 1'b1))
    else $error("found range and count disagree");

  a_empty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.found |->
      out_word_i.range_left == srbs_pkg::ROW_W'(1) && out_word_i.range_right == '0 &&
      out_word_i.match_count == '0)
    else $error("empty result is not canonical");

  // Table writes never hold up the input side.
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && in_word_i.action != srbs_pkg::ACT_PATTERN |=> !in_stall_i)
    else $error("input stalled after a table write");

  a_pattern_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && in_word_i.action == srbs_pkg::ACT_PATTERN |=> in_stall_i)
    else $error("input taken while a pattern byte is in work");

endmodule

bind suffix_range_backward_search_core srbs_checker u_srbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_i  (out_word_o)
);
